// File: sv/ohps_pkg.sv
`default_nettype none

package ohps_pkg;

  localparam int ID_W       = 32;
  localparam int PRIO_REQ_W = 16;

  // command codes
  localparam logic [1:0] CMD_ARRIVE  = 2'd0;
  localparam logic [1:0] CMD_OLDEST  = 2'd1;
  localparam logic [1:0] CMD_HIGHEST = 2'd2;

  // result status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_SERVED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FIN   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// File: sv/ohps_ram.sv
`default_nettype none

module ohps_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/oldest_or_highest_priority_scheduler.sv
// channel | handshake           | fields
// --------+---------------------+---------------------------------
// in      | in_valid / in_stall | cmd[1:0], priority_req[15:0]
// out     | out_valid/out_stall | status[1:0], entry_id[31:0]
//
// One word at a time. An arrival, a refusal or a serve with nothing waiting skips S_SCAN.
// A serve walks the waiting window through the slot RAM's single read port,
// one slot a cycle, over a window of DEPTH slots at most.
// After reset a clearing pass writes all DEPTH slots, in_stall held high.
// A result held by out_stall blocks the next word only once its own work is done.
`default_nettype none

module oldest_or_highest_priority_scheduler #(
  parameter int DEPTH         = 64,
  parameter int PRIORITY_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] priority_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      entry_id
);

  localparam int PW = (PRIORITY_BITS < ohps_pkg::PRIO_REQ_W) ? PRIORITY_BITS
                                                             : ohps_pkg::PRIO_REQ_W;
  localparam int SW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = ohps_pkg::ID_W;

  ohps_pkg::state_t state;

  logic [IW-1:0] oldest_id, next_id;
  logic [SW-1:0] oldest_slot, next_slot;
  logic [SW-1:0] clr_idx;

  // scan pipeline: read issue and check of returned word
  logic [IW-1:0] rd_id, chk_id;
  logic [SW-1:0] rd_slot, chk_slot;
  logic [CW-1:0] rd_left;
  logic          chk_valid;

  logic          op_oldest;
  logic          f1_v, f2_v;
  logic [IW-1:0] f1_id, f2_id, best_id;
  logic [SW-1:0] f1_slot, f2_slot, best_slot;
  logic [PW-1:0] best_prio;

  logic [1:0]    res_status;
  logic [IW-1:0] res_id;

  logic          we;
  logic [SW-1:0] waddr, raddr;
  logic [PW:0]   wdata, rdata;

  logic [IW-1:0] win;
  logic          full, accept, hit;
  logic [SW-1:0] rem_slot;
  logic [IW-1:0] new_oldest;
  logic [SW-1:0] new_oldest_slot;

  // slot of id+1, given slot of id; the id wrap restarts at slot zero
  function automatic logic [SW-1:0] slot_inc(input logic [IW-1:0] id,
                                             input logic [SW-1:0] s);
    if (id == {IW{1'b1}}) begin
      return '0;
    end else if (s == SW'(DEPTH - 1)) begin
      return '0;
    end else begin
      return s + SW'(1);
    end
  endfunction

  assign win      = next_id - oldest_id;
  assign full     = win >= IW'(DEPTH);
  assign in_stall = (state != ohps_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  // removal target and where the oldest pointer lands after it
  assign hit      = op_oldest || f1_v;
  assign rem_slot = op_oldest ? oldest_slot : best_slot;

  always_comb begin
    if (f1_v && (f1_slot != rem_slot)) begin
      new_oldest      = f1_id;
      new_oldest_slot = f1_slot;
    end else if (f2_v) begin
      new_oldest      = f2_id;
      new_oldest_slot = f2_slot;
    end else begin
      new_oldest      = next_id;
      new_oldest_slot = next_slot;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_idx;
    wdata = '0;
    raddr = rd_slot;
    case (state)
      ohps_pkg::S_CLEAR: begin
        we = 1'b1;
      end
      ohps_pkg::S_IDLE: begin
        if (accept && (cmd == ohps_pkg::CMD_ARRIVE) && !full) begin
          we    = 1'b1;
          waddr = next_slot;
          wdata = {1'b1, priority_req[PW-1:0]};
        end
      end
      ohps_pkg::S_FIN: begin
        if (hit) begin
          we    = 1'b1;
          waddr = rem_slot;
        end
      end
      default: begin
      end
    endcase
  end

  ohps_ram #(
    .WIDTH(PW + 1),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ohps_pkg::S_CLEAR;
      clr_idx     <= '0;
      oldest_id   <= IW'(1);
      next_id     <= IW'(1);
      oldest_slot <= SW'(1);
      next_slot   <= SW'(1);
      chk_valid   <= 1'b0;
      rd_left     <= '0;
      f1_v        <= 1'b0;
      f2_v        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ohps_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ohps_pkg::S_CLEAR: begin
          clr_idx <= clr_idx + SW'(1);
          if (clr_idx == SW'(DEPTH - 1)) begin
            state <= ohps_pkg::S_IDLE;
          end
        end
        ohps_pkg::S_IDLE: begin
          if (accept) begin
            op_oldest  <= (cmd == ohps_pkg::CMD_OLDEST);
            f1_v       <= 1'b0;
            f2_v       <= 1'b0;
            chk_valid  <= 1'b0;
            rd_id      <= oldest_id;
            rd_slot    <= oldest_slot;
            rd_left    <= win[CW-1:0];
            case (cmd)
              ohps_pkg::CMD_ARRIVE: begin
                state <= ohps_pkg::S_DONE;
                if (full) begin
                  res_status <= ohps_pkg::ST_FULL;
                  res_id     <= '0;
                end else begin
                  res_status <= ohps_pkg::ST_ACCEPTED;
                  res_id     <= next_id;
                  next_id    <= next_id + IW'(1);
                  next_slot  <= slot_inc(next_id, next_slot);
                end
              end
              ohps_pkg::CMD_OLDEST, ohps_pkg::CMD_HIGHEST: begin
                res_status <= ohps_pkg::ST_EMPTY;
                res_id     <= '0;
                if (win != '0) begin
                  state <= ohps_pkg::S_SCAN;
                end else begin
                  state <= ohps_pkg::S_DONE;
                end
              end
              default: begin
                res_status <= ohps_pkg::ST_EMPTY;
                res_id     <= '0;
                state      <= ohps_pkg::S_DONE;
              end
            endcase
          end
        end
        ohps_pkg::S_SCAN: begin
          if (rd_left != '0) begin
            chk_valid <= 1'b1;
            chk_id    <= rd_id;
            chk_slot  <= rd_slot;
            rd_id     <= rd_id + IW'(1);
            rd_slot   <= slot_inc(rd_id, rd_slot);
            rd_left   <= rd_left - CW'(1);
          end else begin
            chk_valid <= 1'b0;
          end
          if (chk_valid && rdata[PW]) begin
            // strict compare: earliest wins a tie
            if (!f1_v || (rdata[PW-1:0] > best_prio)) begin
              best_prio <= rdata[PW-1:0];
              best_id   <= chk_id;
              best_slot <= chk_slot;
            end
            if (!f1_v) begin
              f1_v    <= 1'b1;
              f1_id   <= chk_id;
              f1_slot <= chk_slot;
            end else if (!f2_v && (chk_slot != f1_slot)) begin
              f2_v    <= 1'b1;
              f2_id   <= chk_id;
              f2_slot <= chk_slot;
            end
          end
          if ((rd_left == '0) && !chk_valid) begin
            state <= ohps_pkg::S_FIN;
          end
        end
        ohps_pkg::S_FIN: begin
          if (hit) begin
            res_status  <= ohps_pkg::ST_SERVED;
            res_id      <= op_oldest ? oldest_id : best_id;
            oldest_id   <= new_oldest;
            oldest_slot <= new_oldest_slot;
          end
          state <= ohps_pkg::S_DONE;
        end
        ohps_pkg::S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            entry_id  <= res_id;
            state     <= ohps_pkg::S_IDLE;
          end
        end
        default: begin
          state <= ohps_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    (next_id - oldest_id) <= IW'(DEPTH))
    else $error("waiting window longer than DEPTH");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("second word taken while one is in progress");

  a_arrival_id: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == ohps_pkg::CMD_ARRIVE) && !full)
      |=> (next_id == $past(next_id) + IW'(1)) && (res_id == $past(next_id)))
    else $error("arrival did not take the next id");

  a_scan_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ohps_pkg::S_FIN) |-> ((rd_left == '0) && !chk_valid))
    else $error("scan finished with reads outstanding");

endmodule

`default_nettype wire

// File: test/tb_oldest_or_highest_priority_scheduler.sv
`timescale 1ns / 100ps

module tb_oldest_or_highest_priority_scheduler;

  localparam int DEPTH           = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PRIO_REQ_W      = ohps_pkg::PRIO_REQ_W;
  localparam int ID_W            = ohps_pkg::ID_W;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [PRIO_REQ_W-1:0] prio;
  } word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] entry_id;
  } outcome_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic [1:0]            cmd          = ohps_pkg::CMD_ARRIVE;
  logic [PRIO_REQ_W-1:0] priority_req = '0;
  logic                  out_stall    = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [1:0]            status;
  logic [ID_W-1:0]       entry_id;

  oldest_or_highest_priority_scheduler #(
    .DEPTH        (DEPTH),
    .PRIORITY_BITS(PRIO_REQ_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .priority_req(priority_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_id    (entry_id)
  );

  // shadow of the waiting table
  logic [PRIO_REQ_W-1:0] slot_prio    [DEPTH];
  bit                    slot_waiting [DEPTH];
  logic [ID_W-1:0]       earliest_id = 1;
  logic [ID_W-1:0]       issue_id    = 1;

  word_t    pending_words[$];
  outcome_t awaited_outcomes[$];
  outcome_t predicted;
  outcome_t due;
  bit       word_taken;
  int       fail_count     = 0;
  int       sender_idle_pct = 0;
  int       recv_stall_pct  = 0;
  int       hold_off_asked  = 0;
  int       hold_off_seen   = 0;
  int       hold_left       = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  // move the earliest id past entries already served by either policy
  task automatic skip_retired();
    for (int n = 0; n < DEPTH && earliest_id != issue_id; n++) begin
      if (slot_waiting[earliest_id % DEPTH]) break;
      earliest_id++;
    end
  endtask

  task automatic predict_outcome(input word_t w, output outcome_t o);
    logic [ID_W-1:0]       span;
    logic [ID_W-1:0]       cand;
    logic [PRIO_REQ_W-1:0] best;
    logic                  found;
    span       = issue_id - earliest_id;
    best       = '0;
    found      = 1'b0;
    o.status   = ohps_pkg::ST_EMPTY;
    o.entry_id = '0;
    case (w.cmd)
      ohps_pkg::CMD_ARRIVE: begin
        if (span >= DEPTH) begin
          o.status = ohps_pkg::ST_FULL;
        end else begin
          slot_prio[issue_id % DEPTH]    = w.prio;
          slot_waiting[issue_id % DEPTH] = 1'b1;
          o.entry_id = issue_id;
          o.status   = ohps_pkg::ST_ACCEPTED;
          issue_id++;
        end
      end
      ohps_pkg::CMD_OLDEST: begin
        if (span != 0) begin
          o.entry_id = earliest_id;
          slot_waiting[earliest_id % DEPTH] = 1'b0;
          skip_retired();
          o.status = ohps_pkg::ST_SERVED;
        end
      end
      ohps_pkg::CMD_HIGHEST: begin
        // strict compare keeps the earliest on a tie
        for (int k = 0; k < DEPTH && k < span; k++) begin
          cand = earliest_id + k;
          if (slot_waiting[cand % DEPTH] && (!found || slot_prio[cand % DEPTH] > best)) begin
            found      = 1'b1;
            best       = slot_prio[cand % DEPTH];
            o.entry_id = cand;
          end
        end
        if (found) begin
          slot_waiting[o.entry_id % DEPTH] = 1'b0;
          skip_retired();
          o.status = ohps_pkg::ST_SERVED;
        end
      end
      default: ;
    endcase
  endtask

  // driver: take note of acceptance at the rising edge, drive at the falling one
  always @(posedge clk) begin
    word_taken = !rst && in_valid && !in_stall;
    if (word_taken) begin
      predict_outcome(pending_words[0], predicted);
      awaited_outcomes.insert(awaited_outcomes.size(), predicted);
      void'(pending_words.pop_front());
    end
    @(negedge clk);
    if (!rst && (!in_valid || word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid     <= 1'b1;
        cmd          <= pending_words[0].cmd;
        priority_req <= pending_words[0].prio;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_off_seen != hold_off_asked) begin
      hold_off_seen = hold_off_asked;
      hold_left     = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected word: status %0d id %0d", status, entry_id));
      end else begin
        due = awaited_outcomes.pop_front();
        if (status !== due.status)
          report_mismatch($sformatf("status %0d, wanted %0d", status, due.status));
        if (entry_id !== due.entry_id)
          report_mismatch($sformatf("entry_id %0d, wanted %0d", entry_id, due.entry_id));
      end
    end
  end

  function automatic logic [PRIO_REQ_W-1:0] rand_prio();
    case ($urandom_range(3))
      0:       return PRIO_REQ_W'($urandom_range(3));   // narrow range, plenty of ties
      1:       return $urandom_range(1) ? '1 : '0;
      default: return PRIO_REQ_W'($urandom);
    endcase
  endfunction

  task automatic add_word(input logic [1:0] c, input logic [PRIO_REQ_W-1:0] p);
    word_t w;
    w.cmd  = c;
    w.prio = p;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_serve();
    int r;
    r = $urandom_range(99);
    if (r < 3)       add_word(CMD_UNUSED, rand_prio());
    else if (r < 50) add_word(ohps_pkg::CMD_OLDEST, rand_prio());
    else             add_word(ohps_pkg::CMD_HIGHEST, rand_prio());
  endtask

  task automatic add_mixed(input int n, input int arrive_pct);
    repeat (n) begin
      if ($urandom_range(99) < arrive_pct) add_word(ohps_pkg::CMD_ARRIVE, rand_prio());
      else add_serve();
    end
  endtask

  task automatic wait_settled();
    while (pending_words.size() != 0 || awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // serves on an empty table and the unused code
    add_word(ohps_pkg::CMD_OLDEST, 16'h1234);
    add_word(ohps_pkg::CMD_HIGHEST, 16'hFFFF);
    add_word(CMD_UNUSED, 16'h0000);
    add_word(ohps_pkg::CMD_ARRIVE, 16'h0000);
    add_word(ohps_pkg::CMD_ARRIVE, 16'hFFFF);
    add_word(ohps_pkg::CMD_ARRIVE, 16'h8000);
    add_word(ohps_pkg::CMD_ARRIVE, 16'hFFFF);
    add_word(ohps_pkg::CMD_ARRIVE, 16'h0001);
    add_word(ohps_pkg::CMD_HIGHEST, 16'h0000);
    add_word(ohps_pkg::CMD_HIGHEST, 16'h0000);   // tie with an earlier one already gone
    add_word(ohps_pkg::CMD_OLDEST, 16'h0000);
    add_word(ohps_pkg::CMD_OLDEST, 16'hFFFF);    // must skip entries served by priority
    add_word(CMD_UNUSED, 16'hFFFF);
    add_word(ohps_pkg::CMD_ARRIVE, 16'h5555);
    add_word(ohps_pkg::CMD_ARRIVE, 16'hAAAA);
    add_word(ohps_pkg::CMD_HIGHEST, 16'h0000);
    add_word(ohps_pkg::CMD_OLDEST, 16'h0000);
    add_word(ohps_pkg::CMD_OLDEST, 16'h0000);
    add_word(ohps_pkg::CMD_OLDEST, 16'h0000);
    add_word(ohps_pkg::CMD_HIGHEST, 16'h0000);
    wait_settled();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 61; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin sender_idle_pct = 7;  recv_stall_pct = 7;  end
      endcase
      add_mixed(20, $urandom_range(20, 80));
      // run the table into its full limit, then drain it past empty
      repeat (66) add_word(ohps_pkg::CMD_ARRIVE, rand_prio());
      repeat (68) add_serve();
      wait_settled();
    end

    // long receiver hold-off while words keep coming
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_off_asked++;
    add_mixed(40, 60);
    wait_settled();

    repeat (DEPTH + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
